[hw/rtl/digit_bucket_store_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the digit bucket store
// Shared property shorthands; each expects clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef DIGIT_BUCKET_STORE_UNIT_MACROS_SVH
`define DIGIT_BUCKET_STORE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/dbs_pkg.sv]
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared constants, codes, command and status types of the bucket store.
// ----------------------------------------------------------------------------
`default_nettype none

package dbs_pkg;

   localparam int NUM_BUCKETS    = 10;
   localparam int BKT_BITS       = 4;
   localparam int OP_BITS        = 2;
   localparam int ITEM_BITS      = 8;
   localparam int STATUS_BITS    = 2;
   localparam int REMOVED_BITS   = 6;
   localparam int MAX_VALUE_BITS = 16;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LIST   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic walk_start;
      logic rd_issue;
      logic list_load;
      logic del_step;
      logic ins_commit;
      logic del_commit;
      logic empty_emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               list_empty;
      logic               more;
      logic               pend;
      logic               out_free;
   } sts_type;

   // Remainder by ten through a reciprocal multiply; exact for 8-bit inputs.
   function automatic logic [BKT_BITS-1:0] mod10(input logic [ITEM_BITS-1:0] v);
      logic [15:0]          prod;
      logic [4:0]           quot;
      logic [ITEM_BITS-1:0] tens;
      logic [ITEM_BITS-1:0] rem;
      prod = 16'(v) * 16'd205;
      quot = prod[15:11];
      tens = 8'(quot) * 8'd10;
      rem  = v - tens;
      return rem[BKT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/dbs_ram.sv]
// ----------------------------------------------------------------------------
// dbs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dbs_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 320,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/dbs_ctrl.sv]
// ----------------------------------------------------------------------------
// dbs_ctrl
// Sequencer for insert, list and delete requests of the bucket store.
// ----------------------------------------------------------------------------
`default_nettype none

module dbs_ctrl
   import dbs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DECODE,
      LIST,
      DELETE,
      DEL_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = DECODE;
            end
         end
         DECODE: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.out_free) begin
                     cmd.ins_commit = 1'b1;
                     state_in       = IDLE;
                  end
               end
               OP_LIST: begin
                  if (sts.list_empty) begin
                     if (sts.out_free) begin
                        cmd.empty_emit = 1'b1;
                        state_in       = IDLE;
                     end
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = LIST;
                  end
               end
               OP_DELETE: begin
                  cmd.walk_start = 1'b1;
                  state_in       = DELETE;
               end
               default: begin
                  state_in = IDLE;
               end
            endcase
         end
         LIST: begin
            // Read data is held in the RAM until the output register takes it.
            cmd.list_load = sts.pend && sts.out_free;
            cmd.rd_issue  = sts.more && (!sts.pend || cmd.list_load);
            if (cmd.list_load && !sts.more) begin
               state_in = IDLE;
            end
         end
         DELETE: begin
            cmd.rd_issue = sts.more;
            cmd.del_step = sts.pend;
            if (!sts.more && !sts.pend) begin
               state_in = DEL_DONE;
            end
         end
         DEL_DONE: begin
            if (sts.out_free) begin
               cmd.del_commit = 1'b1;
               state_in       = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/dbs_datapath.sv]
// ----------------------------------------------------------------------------
// dbs_datapath
// Bucket counts, entry RAM, walk indexes and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "digit_bucket_store_unit_macros.svh"

module dbs_datapath
   import dbs_pkg::*;
#(
   parameter int BUCKET_DEPTH = 32,
   parameter int VALUE_BITS   = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [OP_BITS-1:0]      req_operation,
   input  wire logic [ITEM_BITS-1:0]    req_value,
   input  wire logic [BKT_BITS-1:0]     req_bucket,
   output logic      [ITEM_BITS-1:0]    rsp_item,
   output logic                         rsp_last,
   output logic      [STATUS_BITS-1:0]  rsp_status,
   output logic      [REMOVED_BITS-1:0] rsp_removed,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire cmd_type                 cmd,
   output sts_type                      sts
);

   localparam int IDX_BITS  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(BUCKET_DEPTH + 1);
   localparam int ADDR_BITS = BKT_BITS + IDX_BITS;
   localparam int RAM_DEPTH = NUM_BUCKETS << IDX_BITS;

   logic [OP_BITS-1:0]      op_ff;
   logic [VALUE_BITS-1:0]   val_ff;
   logic [BKT_BITS-1:0]     bkt_ff;
   logic [CNT_BITS-1:0]     rd_idx_ff;
   logic [CNT_BITS-1:0]     wr_idx_ff;
   logic                    pend_ff;
   logic [CNT_BITS-1:0]     cnt_ff [NUM_BUCKETS];
   logic [ITEM_BITS-1:0]    item_ff;
   logic                    last_ff;
   logic [STATUS_BITS-1:0]  status_ff;
   logic [REMOVED_BITS-1:0] removed_ff;
   logic                    valid_ff;

   logic [ITEM_BITS-1:0]    item_in;
   logic                    last_in;
   logic [STATUS_BITS-1:0]  status_in;
   logic [REMOVED_BITS-1:0] removed_in;

   logic [MAX_VALUE_BITS-1:0] req_wide;
   logic [VALUE_BITS-1:0]     req_val;
   logic [MAX_VALUE_BITS-1:0] req_val_wide;
   logic [BKT_BITS-1:0]       req_home;
   logic [MAX_VALUE_BITS-1:0] rd_wide;

   logic [CNT_BITS-1:0]   n;
   logic                  full;
   logic                  more;
   logic                  keep;
   logic                  out_load;
   logic [CNT_BITS-1:0]   removed_cnt;

   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [VALUE_BITS-1:0] ram_wr_data;
   logic [ADDR_BITS-1:0]  ram_rd_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;

   // Only the low VALUE_BITS of the value take part; the bucket follows from that.
   assign req_wide     = MAX_VALUE_BITS'(req_value);
   assign req_val      = req_wide[VALUE_BITS-1:0];
   assign req_val_wide = MAX_VALUE_BITS'(req_val);
   assign req_home     = mod10(req_val_wide[ITEM_BITS-1:0]);

   assign n           = (bkt_ff < BKT_BITS'(NUM_BUCKETS)) ? cnt_ff[bkt_ff] : '0;
   assign full        = (n >= CNT_BITS'(BUCKET_DEPTH));
   assign more        = (rd_idx_ff < n);
   assign keep        = (ram_rd_data != val_ff);
   assign removed_cnt = n - wr_idx_ff;
   assign rd_wide     = MAX_VALUE_BITS'(ram_rd_data);
   assign out_load    = cmd.ins_commit || cmd.empty_emit || cmd.del_commit || cmd.list_load;

   assign ram_wr_en   = (cmd.ins_commit && !full) || (cmd.del_step && keep);
   assign ram_wr_addr = cmd.ins_commit ? {bkt_ff, n[IDX_BITS-1:0]}
                                       : {bkt_ff, wr_idx_ff[IDX_BITS-1:0]};
   assign ram_wr_data = cmd.ins_commit ? val_ff : ram_rd_data;
   assign ram_rd_addr = {bkt_ff, rd_idx_ff[IDX_BITS-1:0]};

   dbs_ram #(
      .WIDTH     (VALUE_BITS),
      .DEPTH     (RAM_DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      item_in    = '0;
      last_in    = 1'b1;
      status_in  = ST_OK;
      removed_in = '0;
      if (cmd.list_load) begin
         item_in = rd_wide[ITEM_BITS-1:0];
         last_in = !more;
      end else if (cmd.empty_emit) begin
         status_in = ST_EMPTY;
      end else if (cmd.ins_commit) begin
         status_in = full ? ST_FULL : ST_OK;
      end else if (cmd.del_commit) begin
         status_in  = (removed_cnt == '0) ? ST_EMPTY : ST_OK;
         removed_in = REMOVED_BITS'(removed_cnt);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         val_ff <= req_val;
         bkt_ff <= (req_operation == OP_LIST) ? req_bucket : req_home;
      end
      if (cmd.walk_start) begin
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
      end else begin
         if (cmd.rd_issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (cmd.del_step && keep) begin
            wr_idx_ff <= wr_idx_ff + 1'b1;
         end
      end
      if (out_load) begin
         item_ff    <= item_in;
         last_ff    <= last_in;
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (cmd.walk_start) begin
            pend_ff <= 1'b0;
         end else if (cmd.rd_issue) begin
            pend_ff <= 1'b1;
         end else if (cmd.list_load || cmd.del_step) begin
            pend_ff <= 1'b0;
         end
         if (out_load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         if (cmd.ins_commit && !full) begin
            cnt_ff[bkt_ff] <= n + 1'b1;
         end else if (cmd.del_commit) begin
            cnt_ff[bkt_ff] <= wr_idx_ff;
         end
      end
   end

   assign rsp_item    = item_ff;
   assign rsp_last    = last_ff;
   assign rsp_status  = status_ff;
   assign rsp_removed = removed_ff;
   assign rsp_valid   = valid_ff;

   assign sts.op         = op_ff;
   assign sts.list_empty = (n == '0);
   assign sts.more       = more;
   assign sts.pend       = pend_ff;
   assign sts.out_free   = !valid_ff || rsp_ready;

   `DBS_ASSERT_SAME(a_count_in_range, bkt_ff < BKT_BITS'(NUM_BUCKETS), n <= CNT_BITS'(BUCKET_DEPTH), "bucket count exceeds depth")
   `DBS_ASSERT_SAME(a_no_read_overrun, cmd.rd_issue, !pend_ff || cmd.list_load || cmd.del_step, "read data overwritten before use")
   `DBS_ASSERT_SAME(a_write_behind_read, cmd.del_step, wr_idx_ff < rd_idx_ff, "compaction write index passed read index")
   `DBS_ASSERT_NEXT(a_list_end_marked, cmd.list_load && !more, valid_ff && last_ff, "final listed entry lacks last mark")

endmodule

`default_nettype wire

[hw/rtl/digit_bucket_store_unit.sv]
// ----------------------------------------------------------------------------
// digit_bucket_store_unit
// Digit bucket store: ten buckets of values, each value filed under its decimal
// ones digit. A request on the req_ channel is taken when req_valid and
// req_ready are both high; results leave on the rsp_ channel under the same
// valid/ready rule. An insert appends to the bucket (status full when at
// capacity) and gives one result, registered after the decode state. A list
// request streams the bucket's entries in order, one a cycle while the
// receiver is ready, with rsp_last on the final one; an empty or out-of-range
// bucket gives a single result. A delete compacts its bucket through the
// entry RAM, one entry a cycle, and then gives one result. One request is in
// work at a time. A finished result waits in the output register while the
// next request is taken. A stalled receiver holds the result and pauses a
// list walk. Reset empties every bucket; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_bucket_store_unit
   import dbs_pkg::*;
#(
   parameter int BUCKET_DEPTH = 32,
   parameter int VALUE_BITS   = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [OP_BITS-1:0]      req_operation,
   input  wire logic [ITEM_BITS-1:0]    req_value,
   input  wire logic [BKT_BITS-1:0]     req_bucket,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [ITEM_BITS-1:0]    rsp_item,
   output logic                         rsp_last,
   output logic      [STATUS_BITS-1:0]  rsp_status,
   output logic      [REMOVED_BITS-1:0] rsp_removed
);

   cmd_type cmd;
   sts_type sts;

   dbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dbs_datapath #(
      .BUCKET_DEPTH (BUCKET_DEPTH),
      .VALUE_BITS   (VALUE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_bucket    (req_bucket),
      .rsp_item      (rsp_item),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .rsp_removed   (rsp_removed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .sts           (sts)
   );

endmodule

`default_nettype wire

[test/digit_bucket_store_unit_tb.sv]
// ----------------------------------------------------------------------------
// Digit bucket store testbench
// Drives insert, list and delete requests through the req_ channel and checks
// every rsp_ result against a shadow copy of the ten buckets. Both channels
// stall at random, with one long stretch at full rate.
// ----------------------------------------------------------------------------
module digit_bucket_store_unit_tb;
   import dbs_pkg::*;

   localparam int DEPTH = 32;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEM_TARGET = 300;
   localparam logic [OP_BITS-1:0] OP_IGNORED = 2'd3;

   typedef struct packed {
      logic [ITEM_BITS-1:0]    item;
      logic                    last;
      logic [STATUS_BITS-1:0]  status;
      logic [REMOVED_BITS-1:0] removed;
   } bucket_rsp_type;

   // Shadow of the bucket contents plus the results still owed by the block.
   class bucket_shadow;
      logic [ITEM_BITS-1:0] entries [NUM_BUCKETS][DEPTH];
      int unsigned          counts [NUM_BUCKETS];
      bucket_rsp_type       owed_results [$];
      int                   mismatch_count;

      function new();
         foreach (counts[i]) counts[i] = 0;
         mismatch_count = 0;
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         $display("mismatch: %s", msg);
      endtask

      function void owe(logic [ITEM_BITS-1:0] item, logic last,
                        logic [STATUS_BITS-1:0] status, int unsigned removed);
         bucket_rsp_type r;
         r.item = item;
         r.last = last;
         r.status = status;
         r.removed = REMOVED_BITS'(removed);
         owed_results.push_back(r);
      endfunction

      function void note_request(logic [OP_BITS-1:0] op, logic [ITEM_BITS-1:0] value,
                                 logic [BKT_BITS-1:0] bucket);
         int unsigned b;
         int unsigned n;
         int unsigned kept;
         b = int'(value) % NUM_BUCKETS;
         case (op)
            OP_INSERT: begin
               if (counts[b] >= DEPTH) begin
                  owe('0, 1'b1, ST_FULL, 0);
               end else begin
                  entries[b][counts[b]] = value;
                  counts[b]++;
                  owe('0, 1'b1, ST_OK, 0);
               end
            end
            OP_LIST: begin
               if (int'(bucket) >= NUM_BUCKETS || counts[bucket] == 0) begin
                  owe('0, 1'b1, ST_EMPTY, 0);
               end else begin
                  n = counts[bucket];
                  for (int i = 0; i < n; i++)
                     owe(entries[bucket][i], (i == n - 1), ST_OK, 0);
               end
            end
            OP_DELETE: begin
               n = counts[b];
               kept = 0;
               for (int i = 0; i < n; i++) begin
                  if (entries[b][i] != value) begin
                     entries[b][kept] = entries[b][i];
                     kept++;
                  end
               end
               counts[b] = kept;
               if (n == kept) owe('0, 1'b1, ST_EMPTY, 0);
               else owe('0, 1'b1, ST_OK, n - kept);
            end
            default: begin
            end
         endcase
      endfunction

      task check_result(bucket_rsp_type got);
         bucket_rsp_type want;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result item=%0d last=%0d status=%0d removed=%0d",
                                      got.item, got.last, got.status, got.removed));
            return;
         end
         want = owed_results.pop_front();
         if (got.item !== want.item)
            report_mismatch($sformatf("item %0d, expected %0d", got.item, want.item));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.removed !== want.removed)
            report_mismatch($sformatf("removed %0d, expected %0d", got.removed, want.removed));
      endtask

      task check_leftovers();
         if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OP_BITS-1:0]      req_operation = OP_INSERT;
   logic [ITEM_BITS-1:0]    req_value = '0;
   logic [BKT_BITS-1:0]     req_bucket = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [ITEM_BITS-1:0]    rsp_item;
   logic                    rsp_last;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [REMOVED_BITS-1:0] rsp_removed;

   bucket_shadow shadow;
   int           req_idle_pct = 12;
   int           rsp_idle_pct = 12;
   int           sent_count = 0;

   digit_bucket_store_unit #(
      .BUCKET_DEPTH(DEPTH),
      .VALUE_BITS  (ITEM_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_value    (req_value),
      .req_bucket   (req_bucket),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item     (rsp_item),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status),
      .rsp_removed  (rsp_removed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // Result side: sample at the edge, then pick the next ready value.
   always @(posedge clock) begin
      bucket_rsp_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.item = rsp_item;
            got.last = rsp_last;
            got.status = rsp_status;
            got.removed = rsp_removed;
            shadow.check_result(got);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Called just after a rising edge; returns just after the edge that took it.
   task automatic send_request(logic [OP_BITS-1:0] op, logic [ITEM_BITS-1:0] value,
                               logic [BKT_BITS-1:0] bucket);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         repeat ($urandom_range(3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= value;
      req_bucket <= bucket;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(op, value, bucket);
      if (op != OP_IGNORED) sent_count++;
   endtask

   task automatic send_random_single();
      int          pick;
      int          b;
      logic [ITEM_BITS-1:0] v;
      logic [BKT_BITS-1:0]  lb;
      pick = $urandom_range(99);
      b = $urandom_range(NUM_BUCKETS - 1);
      v = ITEM_BITS'($urandom_range(255));
      lb = ($urandom_range(99) < 85) ? BKT_BITS'($urandom_range(NUM_BUCKETS - 1))
                                     : BKT_BITS'($urandom_range(15, NUM_BUCKETS));
      if (pick < 38) begin
         send_request(OP_INSERT, ($urandom_range(1) ? v : ITEM_BITS'(b + 10 * $urandom_range(2))),
                      BKT_BITS'($urandom_range(15)));
      end else if (pick < 68) begin
         send_request(OP_LIST, ITEM_BITS'($urandom_range(255)), lb);
      end else if (pick < 95) begin
         // Most deletes aim at the small values that inserts favor, so they hit.
         if ($urandom_range(99) < 60) v = ITEM_BITS'(b + 10 * $urandom_range(2));
         send_request(OP_DELETE, v, BKT_BITS'($urandom_range(15)));
      end else begin
         send_request(OP_IGNORED, v, BKT_BITS'($urandom_range(15)));
      end
   endtask

   // Piles values into one bucket, lists it, often deletes a value of its digit.
   task automatic send_fill_burst(bit first);
      int          b;
      int          kmax;
      int          len;
      bit          single;
      logic [ITEM_BITS-1:0] one_val;
      logic [ITEM_BITS-1:0] v;
      b = $urandom_range(NUM_BUCKETS - 1);
      kmax = (255 - b) / 10;
      single = first || $urandom_range(1);
      one_val = ITEM_BITS'(b + 10 * $urandom_range(kmax));
      len = first ? DEPTH + 4 : $urandom_range(DEPTH + 4, 6);
      repeat (len) begin
         if (single) v = one_val;
         else v = ITEM_BITS'(b + 10 * $urandom_range($urandom_range(1) ? 2 : kmax));
         send_request(OP_INSERT, v, BKT_BITS'($urandom_range(15)));
      end
      send_request(OP_LIST, ITEM_BITS'($urandom_range(255)), BKT_BITS'(b));
      if (first || $urandom_range(1))
         send_request(OP_DELETE, one_val, BKT_BITS'($urandom_range(15)));
   endtask

   initial begin
      bit first_burst;
      shadow = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty and out-of-range lists, then a delete of an absent value.
      send_request(OP_LIST, 8'd0, 4'd0);
      send_request(OP_LIST, 8'd255, 4'd15);
      send_request(OP_LIST, 8'd0, 4'd10);
      send_request(OP_DELETE, 8'd7, 4'd0);
      send_request(OP_INSERT, 8'd0, 4'd15);
      send_request(OP_INSERT, 8'd255, 4'd0);
      send_request(OP_INSERT, 8'd10, 4'd0);
      send_request(OP_INSERT, 8'd0, 4'd0);
      send_request(OP_INSERT, 8'd250, 4'd15);
      send_request(OP_LIST, 8'd255, 4'd0);
      send_request(OP_LIST, 8'd0, 4'd5);
      send_request(OP_DELETE, 8'd0, 4'd0);
      send_request(OP_LIST, 8'd0, 4'd0);
      send_request(OP_IGNORED, 8'd255, 4'd15);
      send_request(OP_DELETE, 8'd255, 4'd15);
      send_request(OP_LIST, 8'd0, 4'd5);
      send_request(OP_INSERT, 8'd9, 4'd15);
      send_request(OP_LIST, 8'd0, 4'd9);
      send_request(OP_DELETE, 8'd250, 4'd15);
      send_request(OP_IGNORED, 8'd0, 4'd0);
      send_request(OP_LIST, 8'd0, 4'd0);

      first_burst = 1'b1;
      while (sent_count < ITEM_TARGET) begin
         if (sent_count >= 150 && sent_count < 230) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 12;
            rsp_idle_pct = 12;
         end
         if (first_burst || $urandom_range(99) < 35) begin
            send_fill_burst(first_burst);
            first_burst = 1'b0;
         end else begin
            send_random_single();
         end
      end
      req_valid <= 1'b0;
      rsp_idle_pct = 12;

      while (shadow.owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      shadow.check_leftovers();
      if (shadow.mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
